FILE: rtl/mfmct_pkg.sv
package mfmct_pkg;

  localparam int POS_W  = 18;
  localparam int LEN_W  = 19;
  localparam int BYTE_W = 8;

  localparam int MIN_TRACK_CELLS  = 16;
  localparam int TRACK_LENGTH_RST = 100000;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // cell store port controls
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

endpackage

FILE: rtl/mfmct_mod_unit.sv
module mfmct_mod_unit #(
  parameter int VW = 18,
  parameter int LW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [VW-1:0] dividend_i,
  input  logic [LW-1:0] divisor_i,
  output logic          done_o,
  output logic [LW-1:0] rem_o
);
  import mfmct_pkg::*;

  localparam int CNTW = (VW > 1) ? $clog2(VW) : 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [VW-1:0]   dvd_q, dvd_d;
  logic [LW-1:0]   div_q, div_d;
  logic [LW:0]     rem_q, rem_d;
  logic [LW:0]     rem_sh;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    rem_sh = {rem_q[LW-1:0], dvd_q[VW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(VW - 1);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = rem_sh - {1'b0, div_q};
      end else begin
        rem_d = rem_sh;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[LW-1:0];

endmodule

FILE: rtl/mfmct_cell_store.sv
module mfmct_cell_store #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mfmct_pkg::mem_cmd_t            cmd_i,
  input  logic [AW-1:0]                  rd_addr_i,
  input  logic [AW-1:0]                  wr_addr_i,
  input  logic [mfmct_pkg::BYTE_W-1:0]   wdata_i,
  output logic [mfmct_pkg::BYTE_W-1:0]   rdata_o,
  output logic                           ready_o
);
  import mfmct_pkg::*;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic              clr_q;
  logic [AW-1:0]     clr_addr_q;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [BYTE_W-1:0] wdata;

  // clearing sweep owns the write port after reset
  assign we    = clr_q | cmd_i.wr;
  assign waddr = clr_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_q ? '0 : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = ~clr_q;

endmodule

FILE: rtl/mfm_circular_track_codec.sv
// a start cell at or beyond the track length is first reduced modulo the length by the
// remainder unit (18 remainder steps at the default size) before the cells are coded
// throughput: one item at a time; the 16 cells go through one at a time, plus a store
// load for each store byte touched, and a write reads the cell before the cursor first
// reset: cursor zero, length 100000; the cell store is cleared one byte per cycle, all
// MAX_TRACK_CELLS/8 bytes (32768 by default), with input stalled meanwhile
module mfm_circular_track_codec #(
  parameter int MAX_TRACK_CELLS = 262144
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mfmct_pkg::LEN_W-1:0]    cfg_track_length_i,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic                           seek_i,
  input  logic [mfmct_pkg::POS_W-1:0]    position_i,
  input  logic [mfmct_pkg::BYTE_W-1:0]   data_byte_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mfmct_pkg::BYTE_W-1:0]   decoded_byte_o,
  output logic [mfmct_pkg::POS_W-1:0]    byte_position_o,
  output logic [mfmct_pkg::POS_W-1:0]    next_position_o
);
  import mfmct_pkg::*;

  localparam int CW          = $clog2(MAX_TRACK_CELLS);
  localparam int LW          = $clog2(MAX_TRACK_CELLS + 1);
  localparam int VW          = (POS_W > CW) ? POS_W : CW;
  localparam int CMPW        = (VW > LW) ? VW : LW;
  localparam int CFGW        = (LEN_W > LW) ? LEN_W : LW;
  localparam int STORE_BYTES = (MAX_TRACK_CELLS + 7) / 8;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int LEN_RST     = (TRACK_LENGTH_RST > MAX_TRACK_CELLS) ? MAX_TRACK_CELLS :
                               TRACK_LENGTH_RST;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MOD     = 3'd1;
  localparam logic [2:0] S_PREV    = 3'd2;
  localparam logic [2:0] S_PREV_LD = 3'd3;
  localparam logic [2:0] S_RD      = 3'd4;
  localparam logic [2:0] S_LOAD    = 3'd5;
  localparam logic [2:0] S_CELL    = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [LW-1:0]     len_q, len_d;
  logic [CW-1:0]     cur_q, cur_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     start_q, start_d;
  logic              rd_op_q, rd_op_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              prev_q, prev_d;
  logic [2:0]        pbit_q, pbit_d;
  logic [BYTE_W-1:0] buf_q, buf_d;
  logic [15:0]       cells_q, cells_d;
  logic [3:0]        cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] dec_q, dec_d;
  logic [POS_W-1:0]  bpos_q, bpos_d;
  logic [POS_W-1:0]  npos_q, npos_d;

  logic              accept;
  logic [VW-1:0]     val;
  logic              val_lt;
  logic              mod_start;
  logic              mod_done;
  logic [LW-1:0]     mod_rem;

  mem_cmd_t          mem_cmd;
  logic [AW-1:0]     mem_rd_addr;
  logic [AW-1:0]     mem_wr_addr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;
  logic              store_ready;

  logic [CW-1:0]     prev_pos;
  logic [LW-1:0]     pos_inc;
  logic [CW-1:0]     nxt_pos;
  logic [2:0]        bi;
  logic              cell_val;
  logic [BYTE_W-1:0] buf_upd;
  logic [BYTE_W-1:0] decoded;
  logic [CFGW-1:0]   cfg_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = ~(state_q == S_IDLE && store_ready);
  assign accept      = in_valid_i & ~in_stall_o;

  assign val    = seek_i ? VW'(position_i) : VW'(cur_q);
  assign val_lt = CMPW'(val) < CMPW'(len_q);
  assign mod_start = accept & ~val_lt;

  // the cell before the cursor wraps to the last cell of the track
  assign prev_pos = (pos_q == '0) ? CW'(len_q - LW'(1)) : (pos_q - 1'b1);
  assign pos_inc  = LW'(pos_q) + LW'(1);
  assign nxt_pos  = (pos_inc >= len_q) ? '0 : CW'(pos_inc);
  assign bi       = 3'd7 - pos_q[2:0];

  // mfm cell: data 1 -> 01, data 0 -> 10 unless the cell before is 1, then 00
  assign cell_val = cnt_q[0] ? data_q[BYTE_W-1] : (~data_q[BYTE_W-1] & ~prev_q);

  always_comb begin
    buf_upd     = buf_q;
    buf_upd[bi] = cell_val;
  end

  always_comb begin
    decoded = '0;
    for (int i = 0; i < 8; i++) begin
      decoded[7-i] = ~cells_q[15-2*i] & cells_q[14-2*i];
    end
  end

  assign cfg_ext = CFGW'(cfg_track_length_i);

  always_comb begin
    len_d = len_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_ext < CFGW'(MIN_TRACK_CELLS)) begin
        len_d = LW'(MIN_TRACK_CELLS);
      end else if (cfg_ext > CFGW'(MAX_TRACK_CELLS)) begin
        len_d = LW'(MAX_TRACK_CELLS);
      end else begin
        len_d = LW'(cfg_ext);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    start_d     = start_q;
    rd_op_d     = rd_op_q;
    data_d      = data_q;
    prev_d      = prev_q;
    pbit_d      = pbit_q;
    buf_d       = buf_q;
    cells_d     = cells_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    dec_d       = dec_q;
    bpos_d      = bpos_q;
    npos_d      = npos_q;
    mem_cmd     = '0;
    mem_rd_addr = AW'(pos_q >> 3);
    mem_wr_addr = AW'(pos_q >> 3);
    mem_wdata   = buf_upd;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_op_d = (req_type_i == REQ_READ);
          data_d  = data_byte_i;
          cnt_d   = '0;
          if (val_lt) begin
            pos_d   = CW'(val);
            start_d = CW'(val);
            state_d = (req_type_i == REQ_READ) ? S_RD : S_PREV;
          end else begin
            state_d = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          pos_d   = CW'(mod_rem);
          start_d = CW'(mod_rem);
          state_d = rd_op_q ? S_RD : S_PREV;
        end
      end
      S_PREV: begin
        mem_cmd.rd  = 1'b1;
        mem_rd_addr = AW'(prev_pos >> 3);
        pbit_d      = 3'd7 - prev_pos[2:0];
        state_d     = S_PREV_LD;
      end
      S_PREV_LD: begin
        prev_d     = mem_rdata[pbit_q];
        mem_cmd.rd = 1'b1;
        state_d    = S_LOAD;
      end
      S_RD: begin
        mem_cmd.rd = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        buf_d   = mem_rdata;
        state_d = S_CELL;
      end
      S_CELL: begin
        cells_d = {cells_q[14:0], buf_q[bi]};
        if (!rd_op_q) begin
          buf_d = buf_upd;
        end
        if (cnt_q[0]) begin
          prev_d = data_q[BYTE_W-1];
          data_d = data_q << 1;
        end
        pos_d = nxt_pos;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd15) begin
          mem_cmd.wr = ~rd_op_q;
          state_d    = S_DONE;
        end else if (nxt_pos[2:0] == 3'd0) begin
          // leaving this store byte: write it back on a write and fetch the next
          mem_cmd.wr  = ~rd_op_q;
          mem_cmd.rd  = 1'b1;
          mem_rd_addr = AW'(nxt_pos >> 3);
          state_d     = S_LOAD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          dec_d       = rd_op_q ? decoded : '0;
          bpos_d      = POS_W'(start_q);
          npos_d      = POS_W'(pos_q);
          cur_d       = pos_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= LW'(LEN_RST);
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    start_q <= start_d;
    rd_op_q <= rd_op_d;
    data_q  <= data_d;
    prev_q  <= prev_d;
    pbit_q  <= pbit_d;
    buf_q   <= buf_d;
    cells_q <= cells_d;
    cnt_q   <= cnt_d;
    dec_q   <= dec_d;
    bpos_q  <= bpos_d;
    npos_q  <= npos_d;
  end

  mfmct_mod_unit #(
    .VW(VW),
    .LW(LW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(val),
    .divisor_i (len_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  mfmct_cell_store #(
    .DEPTH(STORE_BYTES),
    .AW   (AW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mem_cmd),
    .rd_addr_i(mem_rd_addr),
    .wr_addr_i(mem_wr_addr),
    .wdata_i  (mem_wdata),
    .rdata_o  (mem_rdata),
    .ready_o  (store_ready)
  );

  assign out_valid_o     = out_valid_q;
  assign decoded_byte_o  = dec_q;
  assign byte_position_o = bpos_q;
  assign next_position_o = npos_q;

endmodule

FILE: rtl/mfmct_checker.sv
module mfmct_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [mfmct_pkg::BYTE_W-1:0] decoded_byte_o,
  input logic [mfmct_pkg::POS_W-1:0]  byte_position_o,
  input logic [mfmct_pkg::POS_W-1:0]  next_position_o
);
  import mfmct_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(decoded_byte_o) &&
      $stable(byte_position_o) && $stable(next_position_o))
    else $error("stalled result changed");

  // an accepted item keeps the block busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a transfer");

  // a new result only comes out of a busy block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

  // a result never rises in the cycle after a fresh transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result right after input transfer");

endmodule

bind mfm_circular_track_codec mfmct_checker u_mfmct_checker (.*);

FILE: verif/mfm_circular_track_codec_test.sv
`timescale 1ns / 100ps

module mfm_circular_track_codec_test;
  import mfmct_pkg::*;

  localparam int unsigned TRACK_CELLS  = 262144;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS  = 140;

  typedef struct packed {
    logic              req_type;
    logic              seek;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] data_byte;
  } track_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] decoded;
    logic [POS_W-1:0]  byte_pos;
    logic [POS_W-1:0]  next_pos;
  } track_res_t;

  typedef struct {
    track_req_t rq;
    bit         fixed;
    track_res_t res;
  } directed_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [LEN_W-1:0]  cfg_track_length_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              req_type_i;
  logic              seek_i;
  logic [POS_W-1:0]  position_i;
  logic [BYTE_W-1:0] data_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BYTE_W-1:0] decoded_byte_o;
  logic [POS_W-1:0]  byte_position_o;
  logic [POS_W-1:0]  next_position_o;

  mfm_circular_track_codec #(
    .MAX_TRACK_CELLS(TRACK_CELLS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_track_length_i (cfg_track_length_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .seek_i             (seek_i),
    .position_i         (position_i),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .decoded_byte_o     (decoded_byte_o),
    .byte_position_o    (byte_position_o),
    .next_position_o    (next_position_o)
  );

  always #6 clk_i = ~clk_i;

  // own copy of the track, the cursor and the length register
  bit               track_mem [TRACK_CELLS];
  int unsigned      head_pos;
  logic [LEN_W-1:0] cfg_len;

  track_res_t    byte_results [$];
  directed_row_t directed_rows [$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  bit            in_burst;

  function automatic int unsigned cells_in_use();
    int unsigned l;
    l = 32'(cfg_len);
    if (l < MIN_TRACK_CELLS) l = MIN_TRACK_CELLS;
    if (l > TRACK_CELLS) l = TRACK_CELLS;
    return l;
  endfunction

  function automatic int unsigned next_cell(input int unsigned pos, input int unsigned len);
    return (pos + 1 >= len) ? 0 : pos + 1;
  endfunction

  // encode into or decode from the track, moving the cursor
  function automatic track_res_t track_access(input track_req_t rq);
    int unsigned       len;
    int unsigned       pos;
    int unsigned       start;
    logic [BYTE_W-1:0] acc;
    bit                prev;
    bit                c1;
    bit                c2;
    track_res_t        r;
    len = cells_in_use();
    if (rq.seek) head_pos = 32'(rq.position) % len;
    pos = head_pos % len;
    start = pos;
    acc = '0;
    if (rq.req_type == REQ_READ) begin
      for (int b = BYTE_W - 1; b >= 0; b--) begin
        c1 = track_mem[pos];
        pos = next_cell(pos, len);
        c2 = track_mem[pos];
        pos = next_cell(pos, len);
        if (!c1 && c2) acc[b] = 1'b1;
      end
    end else begin
      // cell before the cursor, wrapping to the end of the track
      prev = track_mem[(pos != 0) ? pos - 1 : len - 1];
      for (int b = BYTE_W - 1; b >= 0; b--) begin
        if (rq.data_byte[b]) begin
          c1 = 1'b0;
          c2 = 1'b1;
        end else if (prev) begin
          c1 = 1'b0;
          c2 = 1'b0;
        end else begin
          c1 = 1'b1;
          c2 = 1'b0;
        end
        track_mem[pos] = c1;
        pos = next_cell(pos, len);
        track_mem[pos] = c2;
        pos = next_cell(pos, len);
        prev = c2;
      end
    end
    head_pos = pos;
    r.decoded = acc;
    r.byte_pos = start[POS_W-1:0];
    r.next_pos = pos[POS_W-1:0];
    return r;
  endfunction

  function automatic track_req_t make_req(input logic req, input logic seek,
                                          input int unsigned pos, input int unsigned data);
    track_req_t rq;
    rq.req_type = req;
    rq.seek = seek;
    rq.position = pos[POS_W-1:0];
    rq.data_byte = data[BYTE_W-1:0];
    return rq;
  endfunction

  function automatic int unsigned pick_position(input int unsigned len);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return len - 1;
      2: return len;
      3: return 32'h3FFFF;
      4: return $urandom;
      default: return $urandom_range(0, len - 1);
    endcase
  endfunction

  function automatic void add_row(input logic req, input logic seek, input int unsigned pos,
                                  input logic [BYTE_W-1:0] data, input bit fixed,
                                  input logic [BYTE_W-1:0] dec, input int unsigned bp,
                                  input int unsigned np);
    directed_row_t row;
    row.rq = make_req(req, seek, pos, 32'(data));
    row.fixed = fixed;
    row.res.decoded = dec;
    row.res.byte_pos = bp[POS_W-1:0];
    row.res.next_pos = np[POS_W-1:0];
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [POS_W-1:0] want,
                                      input logic [POS_W-1:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    track_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (byte_results.size() == 0) begin
        $display("%0t result with nothing pending: expected none actual %0h/%0h/%0h",
                 $time, decoded_byte_o, byte_position_o, next_position_o);
        mismatch_count++;
      end else begin
        want = byte_results.pop_front();
        check_field("decoded_byte", POS_W'(want.decoded), POS_W'(decoded_byte_o));
        check_field("byte_position", want.byte_pos, byte_position_o);
        check_field("next_position", want.next_pos, next_position_o);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input track_req_t rq, input bit fixed, input track_res_t fixed_res);
    int unsigned gap;
    track_res_t  res;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= rq.req_type;
    seek_i      <= rq.seek;
    position_i  <= rq.position;
    data_byte_i <= rq.data_byte;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    res = track_access(rq);
    byte_results.push_back(fixed ? fixed_res : res);
    @(negedge clk_i);
  endtask

  task automatic write_track_length(input logic [LEN_W-1:0] value);
    in_valid_i <= 1'b0;
    while (byte_results.size() != 0) @(negedge clk_i);
    cfg_track_length_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_len = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned cnt;
    int unsigned base;
    int unsigned rb;
    int unsigned len;
    len = cells_in_use();
    // no seek first, so a cursor left beyond a shorter track gets reduced
    send_item(make_req(REQ_READ, 1'b0, $urandom, $urandom), 1'b0, '0);
    sent = 1;
    while (sent < n_items) begin
      in_burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 65) begin
        cnt = $urandom_range(1, 6);
        base = pick_position(len);
        for (int k = 0; k < cnt; k++)
          send_item(make_req(REQ_WRITE, k == 0, base, $urandom), 1'b0, '0);
        // mostly read back in step, now and then one cell off
        rb = ($urandom_range(0, 5) == 0) ? base + 1 : base;
        for (int k = 0; k < cnt; k++)
          send_item(make_req(REQ_READ, k == 0, rb, $urandom), 1'b0, '0);
        sent += 2 * cnt;
      end else begin
        send_item(make_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           pick_position(len), $urandom), 1'b0, '0);
        sent++;
      end
    end
    in_burst = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    bit          sink_burst;
    taken = 0;
    sink_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 64 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT) hold = LONG_HOLD;
      else hold = sink_burst ? 0 : $urandom_range(0, 11);
      @(negedge clk_i);
      out_stall_i <= (hold != 0);
      if (hold > 1) repeat (hold - 1) @(negedge clk_i);
      if (hold != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      taken++;
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[mfm_circular_track_codec] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_lengths [12];
    rst_ni             <= 1'b0;
    cfg_valid_i        <= 1'b0;
    cfg_track_length_i <= '0;
    in_valid_i         <= 1'b0;
    req_type_i         <= REQ_WRITE;
    seek_i             <= 1'b0;
    position_i         <= '0;
    data_byte_i        <= '0;
    out_stall_i        <= 1'b0;
    head_pos = 0;
    cfg_len = LEN_W'(TRACK_LENGTH_RST);
    mismatch_count = 0;
    in_burst = 1'b0;

    // track of 100000 cells after reset
    add_row(REQ_READ,  1'b1, 0,      8'h00, 1'b1, 8'h00, 0,     16);
    add_row(REQ_WRITE, 1'b1, 0,      8'hFF, 1'b1, 8'h00, 0,     16);
    add_row(REQ_READ,  1'b1, 0,      8'h00, 1'b1, 8'hFF, 0,     16);
    add_row(REQ_WRITE, 1'b0, 262143, 8'h00, 1'b1, 8'h00, 16,    32);
    add_row(REQ_READ,  1'b0, 0,      8'hFF, 1'b1, 8'h00, 32,    48);
    add_row(REQ_READ,  1'b1, 16,     8'h00, 1'b1, 8'h00, 16,    32);
    add_row(REQ_WRITE, 1'b1, 262143, 8'hA5, 1'b1, 8'h00, 62143, 62159);
    add_row(REQ_READ,  1'b1, 62143,  8'h00, 1'b1, 8'hA5, 62143, 62159);
    add_row(REQ_WRITE, 1'b1, 99992,  8'h3C, 1'b1, 8'h00, 99992, 8);
    add_row(REQ_READ,  1'b1, 99992,  8'h00, 1'b1, 8'h3C, 99992, 8);
    add_row(REQ_READ,  1'b0, 0,      8'h00, 1'b0, 8'h00, 0,     0);
    // a one in the last cell feeds the first pair of a write at cell zero
    add_row(REQ_WRITE, 1'b1, 99984,  8'hFF, 1'b1, 8'h00, 99984, 0);
    add_row(REQ_WRITE, 1'b1, 0,      8'h00, 1'b1, 8'h00, 0,     16);
    add_row(REQ_WRITE, 1'b1, 1,      8'h00, 1'b1, 8'h00, 1,     17);
    add_row(REQ_READ,  1'b1, 0,      8'h00, 1'b0, 8'h00, 0,     0);
    add_row(REQ_WRITE, 1'b1, 99999,  8'h80, 1'b1, 8'h00, 99999, 15);
    add_row(REQ_READ,  1'b1, 99999,  8'h00, 1'b1, 8'h80, 99999, 15);
    add_row(REQ_WRITE, 1'b0, 0,      8'h01, 1'b1, 8'h00, 15,    31);
    add_row(REQ_WRITE, 1'b0, 0,      8'h55, 1'b1, 8'h00, 31,    47);
    add_row(REQ_WRITE, 1'b0, 0,      8'hAA, 1'b1, 8'h00, 47,    63);
    add_row(REQ_READ,  1'b1, 15,     8'h00, 1'b1, 8'h01, 15,    31);
    add_row(REQ_READ,  1'b0, 0,      8'h00, 1'b1, 8'h55, 31,    47);
    add_row(REQ_READ,  1'b0, 0,      8'h00, 1'b1, 8'hAA, 47,    63);
    add_row(REQ_READ,  1'b1, 100000, 8'h00, 1'b0, 8'h00, 0,     0);
    add_row(REQ_WRITE, 1'b1, 131072, 8'h7E, 1'b1, 8'h00, 31072, 31088);

    phase_lengths = '{16, 0, 262144, 524287, 17, 1023, 15, 100000, 4099, 262143, 31, 5000};

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // the first transfer waits out the store clear
    foreach (directed_rows[i])
      send_item(directed_rows[i].rq, directed_rows[i].fixed, directed_rows[i].res);

    foreach (phase_lengths[i]) begin
      write_track_length(LEN_W'(phase_lengths[i]));
      random_phase(PHASE_ITEMS);
    end

    in_valid_i <= 1'b0;
    while (byte_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[mfm_circular_track_codec] OK");
    end else begin
      $display("[mfm_circular_track_codec] ERROR");
    end
    $finish;
  end

endmodule
